// ----- rtl/core/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the LRU page replacement block
// Holds the sequencer state type, the result word layout and the fixed field
// widths used by the engine and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

	// Fixed field widths of the stream and configuration ports.
	localparam int unsigned PAGE_IN_W  = 16;
	localparam int unsigned FRAME_W    = 4;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned CFG_W      = 5;
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 88;

	// Frame count after reset.
	localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic [COUNT_W-1:0]   hit_total;
		logic [COUNT_W-1:0]   fault_total;
		logic [PAGE_IN_W-1:0] evicted_page;
		logic                 evicted_valid;
		logic [FRAME_W-1:0]   frame_index;
		logic                 hit;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/core/lpr_page_ram.sv -----
// ----------------------------------------------------------------------------
// lpr_page_ram: page number store
// One write port and one read port with registered read data. Entries hold
// no reset value; the engine reads only entries it has marked valid.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_page_ram #(
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned DATA_W = 16,
	parameter int unsigned ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/lpr_engine.sv -----
// ----------------------------------------------------------------------------
// lpr_engine: frame scan sequencer and recency update
// Walks the active frames one per cycle through a single compare stage,
// tracking the first match, the first empty frame and the oldest frame, then
// writes the chosen frame and ages the recency ranks in the update state.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_engine #(
	parameter int unsigned MAX_FRAMES = 16,
	parameter int unsigned PAGE_BITS  = 16,
	parameter int unsigned IDX_W      = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [PAGE_BITS-1:0] page,
	input  wire logic [IDX_W-1:0]     last_idx,
	input  wire logic                 out_free,
	output logic                      ready,
	output logic                      res_valid,
	output lpr_pkg::result_t          res
);

	localparam int unsigned OLD_W = IDX_W + 1;
	localparam logic [OLD_W-1:0] OLD_EMPTY = OLD_W'(MAX_FRAMES);

	lpr_pkg::state_t state_q, state_d;

	logic [PAGE_BITS-1:0] page_q;
	logic [IDX_W-1:0]     scan_q;

	// Compare stage, registered from the scan address along with the read data.
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic [PAGE_BITS-1:0] rd_page;

	// Per-frame state.
	logic [MAX_FRAMES-1:0] valid_q;
	logic [IDX_W-1:0]      rank_q [MAX_FRAMES];

	// Scan trackers.
	logic                 found_q, empty_q;
	logic [IDX_W-1:0]     match_idx_q, empty_idx_q, max_idx_q;
	logic [IDX_W-1:0]     hit_rank_q, max_rank_q;
	logic [PAGE_BITS-1:0] max_page_q;

	logic [lpr_pkg::COUNT_W-1:0] fault_q, hit_q, fault_d, hit_d;

	logic             scan_en, upd;
	logic             cur_valid, cur_match;
	logic [IDX_W-1:0] cur_rank;
	logic [IDX_W-1:0] sel_idx;
	logic [OLD_W-1:0] old_rank;
	logic             ev_valid;

	assign cur_valid = valid_q[cmp_idx_s1];
	assign cur_rank  = rank_q[cmp_idx_s1];
	assign cur_match = cur_valid && (rd_page == page_q);

	always_comb begin
		state_d   = state_q;
		scan_en   = 1'b0;
		upd       = 1'b0;
		ready     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			lpr_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (start) begin
					state_d = lpr_pkg::ST_SCAN;
				end
			end
			lpr_pkg::ST_SCAN: begin
				scan_en = 1'b1;
				if (scan_q == last_idx) begin
					state_d = lpr_pkg::ST_DRAIN;
				end
			end
			lpr_pkg::ST_DRAIN: begin
				state_d = lpr_pkg::ST_UPDATE;
			end
			lpr_pkg::ST_UPDATE: begin
				if (out_free) begin
					upd       = 1'b1;
					res_valid = 1'b1;
					state_d   = lpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	lpr_page_ram #(
		.DEPTH  (MAX_FRAMES),
		.DATA_W (PAGE_BITS),
		.ADDR_W (IDX_W)
	) u_page_ram (
		.clk   (clk),
		.we    (upd),
		.waddr (sel_idx),
		.wdata (page_q),
		.raddr (scan_q),
		.rdata (rd_page)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
			scan_q     <= '0;
		end else begin
			cmp_vld_s1 <= scan_en;
			if (start && ready) begin
				scan_q <= '0;
			end else if (scan_en && (scan_q != last_idx)) begin
				scan_q <= scan_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_q;
		if (start && ready) begin
			page_q <= page;
		end
	end

	// Trackers: the first hit and first hole win; the oldest frame needs a
	// strictly larger rank to displace an earlier candidate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (start && ready) begin
			found_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (cur_match) begin
				found_q <= 1'b1;
			end
			if (!cur_valid) begin
				empty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_vld_s1) begin
			if (cur_match && !found_q) begin
				match_idx_q <= cmp_idx_s1;
				hit_rank_q  <= cur_rank;
			end
			if (!cur_valid && !empty_q) begin
				empty_idx_q <= cmp_idx_s1;
			end
			if ((cmp_idx_s1 == '0) || (cur_rank > max_rank_q)) begin
				max_idx_q  <= cmp_idx_s1;
				max_rank_q <= cur_rank;
				max_page_q <= rd_page;
			end
		end
	end

	always_comb begin
		ev_valid = 1'b0;
		if (found_q) begin
			sel_idx  = match_idx_q;
			old_rank = {1'b0, hit_rank_q};
		end else if (empty_q) begin
			sel_idx  = empty_idx_q;
			old_rank = OLD_EMPTY;
		end else begin
			sel_idx  = max_idx_q;
			old_rank = {1'b0, max_rank_q};
			ev_valid = 1'b1;
		end
	end

	// Recency update: the chosen frame becomes rank zero and every valid frame
	// that was more recent than it ages by one.
	for (genvar gi = 0; gi < MAX_FRAMES; gi++) begin : g_frame
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[gi] <= 1'b0;
				rank_q[gi]  <= '0;
			end else if (upd) begin
				if (sel_idx == IDX_W'(gi)) begin
					valid_q[gi] <= 1'b1;
					rank_q[gi]  <= '0;
				end else if (valid_q[gi] && ({1'b0, rank_q[gi]} < old_rank)) begin
					rank_q[gi] <= rank_q[gi] + 1'b1;
				end
			end
		end
	end

	always_comb begin
		fault_d = fault_q;
		hit_d   = hit_q;
		if (found_q) begin
			if (hit_q != '1) begin
				hit_d = hit_q + 1'b1;
			end
		end else if (fault_q != '1) begin
			fault_d = fault_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= '0;
			hit_q   <= '0;
		end else if (upd) begin
			fault_q <= fault_d;
			hit_q   <= hit_d;
		end
	end

	assign res.hit           = found_q;
	assign res.frame_index   = lpr_pkg::FRAME_W'(sel_idx);
	assign res.evicted_valid = ev_valid;
	assign res.evicted_page  = ev_valid ? lpr_pkg::PAGE_IN_W'(max_page_q) : '0;
	assign res.fault_total   = fault_d;
	assign res.hit_total     = hit_d;

endmodule

`default_nettype wire

// ----- rtl/core/lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// lru_page_replacement: fully associative LRU page frame manager
// Takes one page reference per input word and returns one result word with
// the hit or fault, the frame used, any evicted page and running counts.
// ----------------------------------------------------------------------------
// Each accepted page reference is checked against the active frames one frame
// per cycle through a single compare stage that reads the page store. An item
// passes through an accept step, N scan steps, where N is the effective frame
// count (1 to MAX_FRAMES), a drain step for the store read latency and an
// update step in which the chosen frame is written and the recency ranks are
// aged. s_tready is high only while the block is idle. The finished result
// sits in an output register, so the next reference can be taken while the
// previous result waits for m_tready; the update step waits only if that
// register is still full. The frame count register may be written only while
// the block is idle; zero acts as one and values above MAX_FRAMES act as
// MAX_FRAMES. Frames above the count keep their contents and rejoin when the
// count grows. The hit and fault counts saturate at all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement #(
	parameter int unsigned MAX_FRAMES = 16,
	parameter int unsigned PAGE_BITS  = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	// Frame count register.
	input  wire logic                              cfg_we,
	input  wire logic [lpr_pkg::CFG_W-1:0]         cfg_wdata,

	// Page reference words.
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// tdata: page_number[15:0]
	input  wire logic [lpr_pkg::IN_DATA_W-1:0]     s_tdata,

	// Result words.
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// tdata: hit[0], frame_index[4:1], evicted_valid[5], evicted_page[21:6],
	//        fault_total[53:22], hit_total[85:54], zero fill[87:86]
	output logic [lpr_pkg::OUT_DATA_W-1:0]         m_tdata
);

	localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int unsigned LIM_W = (IDX_W + 1 > lpr_pkg::CFG_W) ? IDX_W + 1 : lpr_pkg::CFG_W;
	localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_FRAMES);

	logic [lpr_pkg::CFG_W-1:0] frames_q;
	logic [LIM_W-1:0]          frames_ext;
	logic [LIM_W-1:0]          frames_eff;
	logic [IDX_W-1:0]          last_idx;

	logic             eng_ready;
	logic             res_valid;
	logic             out_free;
	logic             start;
	lpr_pkg::result_t eng_res;
	lpr_pkg::result_t out_q;
	logic             out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= lpr_pkg::FRAMES_RESET;
		end else if (cfg_we) begin
			frames_q <= cfg_wdata;
		end
	end

	// Clamp the frame count into 1..MAX_FRAMES and turn it into a last index.
	always_comb begin
		frames_ext = LIM_W'(frames_q);
		if (frames_ext == '0) begin
			frames_eff = LIM_W'(1);
		end else if (frames_ext > MAX_LIM) begin
			frames_eff = MAX_LIM;
		end else begin
			frames_eff = frames_ext;
		end
		last_idx = IDX_W'(frames_eff - 1'b1);
	end

	assign s_tready = eng_ready;
	assign start    = s_tvalid && eng_ready;
	assign out_free = !out_vld_q || m_tready;

	lpr_engine #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.IDX_W      (IDX_W)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.page      (PAGE_BITS'(s_tdata)),
		.last_idx  (last_idx),
		.out_free  (out_free),
		.ready     (eng_ready),
		.res_valid (res_valid),
		.res       (eng_res)
	);

	// Output register: loads a finished result, holds it until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= eng_res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_q};

endmodule

`default_nettype wire

// ----- tb/tb_lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// tb_lru_page_replacement: self-checking bench for the LRU page replacement
// A directed table walks reset behavior, empty frame fills, evictions, the
// clamped frame counts and frames rejoining the active set; then random page
// streams run under several frame counts. Every result word is checked against
// an in-bench LRU model and table row; both sides stall at random bar one phase.
// ----------------------------------------------------------------------------

module tb_lru_page_replacement;

	localparam int unsigned FRAME_SLOTS = 16;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_WORDS = 110;
	localparam int unsigned NUM_PHASES  = 10;
	localparam int unsigned HOLD_AFTER  = 400;
	localparam int unsigned HOLD_CYCLES = 500;
	localparam int unsigned MAX_SHOWN   = 10;

	typedef enum logic {
		ROW_PAGE,
		ROW_FRAMES
	} row_kind_t;

	typedef struct {
		row_kind_t                     kind;
		logic [lpr_pkg::PAGE_IN_W-1:0] value;
		bit                            typed;
		logic                          hit;
		logic [lpr_pkg::FRAME_W-1:0]   frame;
		logic                          ev_valid;
		logic [lpr_pkg::PAGE_IN_W-1:0] ev_page;
	} dir_row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [lpr_pkg::CFG_W-1:0]        cfg_wdata;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [lpr_pkg::IN_DATA_W-1:0]    s_tdata;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [lpr_pkg::OUT_DATA_W-1:0]   m_tdata;

	// Model state of the frame set.
	logic [lpr_pkg::PAGE_IN_W-1:0]    frm_page [FRAME_SLOTS];
	logic                             frm_valid [FRAME_SLOTS];
	logic [lpr_pkg::FRAME_W-1:0]      frm_rank [FRAME_SLOTS];
	logic [lpr_pkg::COUNT_W-1:0]      fault_cnt;
	logic [lpr_pkg::COUNT_W-1:0]      hit_cnt;
	logic [lpr_pkg::CFG_W-1:0]        frames_cfg;

	lpr_pkg::result_t                 expected_results [$];
	dir_row_t                         dir_rows [$];
	int unsigned                      mismatch_cnt;
	int unsigned                      words_seen;
	int unsigned                      cycle_cnt;
	int unsigned                      hold_left;
	bit                               hold_done;
	bit                               quiet;

	lru_page_replacement i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned active_count();
		if (frames_cfg == '0) begin
			return 1;
		end
		if (frames_cfg > FRAME_SLOTS) begin
			return FRAME_SLOTS;
		end
		return frames_cfg;
	endfunction

	function automatic logic [lpr_pkg::COUNT_W-1:0] sat_inc(
			input logic [lpr_pkg::COUNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Looks up one page reference, updates the frame set and returns the result word.
	function automatic lpr_pkg::result_t lru_predict(input logic [lpr_pkg::PAGE_IN_W-1:0] pg);
		lpr_pkg::result_t r;
		int unsigned      n;
		int unsigned      f;
		int unsigned      i;
		bit               found;
		bit               empty;
		logic [4:0]       old_rank;
		r = '0;
		n = active_count();
		f = 0;
		found = 1'b0;
		empty = 1'b0;
		for (i = 0; i < n; i++) begin
			if (!found && frm_valid[i] && frm_page[i] == pg) begin
				f = i;
				found = 1'b1;
			end
		end
		if (found) begin
			r.hit = 1'b1;
			hit_cnt = sat_inc(hit_cnt);
		end else begin
			for (i = 0; i < n; i++) begin
				if (!empty && !frm_valid[i]) begin
					f = i;
					empty = 1'b1;
				end
			end
			if (!empty) begin
				// All active frames are full: the highest rank is the oldest.
				f = 0;
				for (i = 1; i < n; i++) begin
					if (frm_rank[i] > frm_rank[f]) begin
						f = i;
					end
				end
				r.evicted_valid = 1'b1;
				r.evicted_page = frm_page[f];
			end
			fault_cnt = sat_inc(fault_cnt);
		end
		// Ranks younger than the touched frame age by one, inactive frames too.
		old_rank = frm_valid[f] ? {1'b0, frm_rank[f]} : 5'(FRAME_SLOTS);
		for (i = 0; i < FRAME_SLOTS; i++) begin
			if (i != f && frm_valid[i] && {1'b0, frm_rank[i]} < old_rank) begin
				frm_rank[i] = frm_rank[i] + 1'b1;
			end
		end
		frm_rank[f] = '0;
		frm_valid[f] = 1'b1;
		frm_page[f] = pg;
		r.frame_index = f[lpr_pkg::FRAME_W-1:0];
		r.fault_total = fault_cnt;
		r.hit_total = hit_cnt;
		return r;
	endfunction

	task automatic add_row(input row_kind_t kind, input logic [lpr_pkg::PAGE_IN_W-1:0] value,
			input bit typed, input logic hit, input logic [lpr_pkg::FRAME_W-1:0] frame,
			input logic ev_valid, input logic [lpr_pkg::PAGE_IN_W-1:0] ev_page);
		dir_row_t row;
		row.kind = kind;
		row.value = value;
		row.typed = typed;
		row.hit = hit;
		row.frame = frame;
		row.ev_valid = ev_valid;
		row.ev_page = ev_page;
		dir_rows.push_back(row);
	endtask

	// Offers one page word; the expectation is queued on acceptance.
	task automatic send_page(input logic [lpr_pkg::PAGE_IN_W-1:0] pg, input bit typed,
			input dir_row_t row);
		lpr_pkg::result_t r;
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 16) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pg;
		do begin
			@(posedge clk);
		end while (!s_tready);
		r = lru_predict(pg);
		if (typed) begin
			r.hit = row.hit;
			r.frame_index = row.frame;
			r.evicted_valid = row.ev_valid;
			r.evicted_page = row.ev_page;
		end
		expected_results.push_back(r);
	endtask

	// The frame count changes only once every result is out and the block is idle.
	task automatic write_frames(input logic [lpr_pkg::CFG_W-1:0] value);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		frames_cfg = value;
	endtask

	// Result checker.
	always @(posedge clk) begin
		lpr_pkg::result_t got;
		lpr_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = lpr_pkg::result_t'(m_tdata[$bits(lpr_pkg::result_t)-1:0]);
			words_seen++;
			if (expected_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_SHOWN) begin
					$display("unexpected result word %h", m_tdata);
				end
			end else begin
				want = expected_results.pop_front();
				if (got.hit !== want.hit || got.frame_index !== want.frame_index ||
						got.evicted_valid !== want.evicted_valid ||
						got.evicted_page !== want.evicted_page ||
						got.fault_total !== want.fault_total ||
						got.hit_total !== want.hit_total) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_SHOWN) begin
						$display("word %0d: exp hit %b frame %0d ev %b/%h faults %0d hits %0d",
							words_seen, want.hit, want.frame_index, want.evicted_valid,
							want.evicted_page, want.fault_total, want.hit_total);
						$display("word %0d: got hit %b frame %0d ev %b/%h faults %0d hits %0d",
							words_seen, got.hit, got.frame_index, got.evicted_valid,
							got.evicted_page, got.fault_total, got.hit_total);
					end
				end
			end
		end
	end

	// Receiver: random stalls, one long hold-off so the block backs up.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && words_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(0, 99) >= 16);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_lru_page_replacement NOT OK");
			$finish;
		end
	end

	initial begin
		logic [lpr_pkg::PAGE_IN_W-1:0] pool [32];
		logic [lpr_pkg::CFG_W-1:0]     phase_frames [NUM_PHASES];
		int unsigned                   pool_size;
		int unsigned                   pick;
		int unsigned                   k;
		int unsigned                   w;
		logic [lpr_pkg::PAGE_IN_W-1:0] pg;
		dir_row_t                      none;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatch_cnt = 0;
		words_seen = 0;
		cycle_cnt = 0;
		hold_left = 0;
		hold_done = 1'b0;
		quiet = 1'b0;
		none = '{ROW_PAGE, '0, 1'b0, 1'b0, '0, 1'b0, '0};
		frames_cfg = lpr_pkg::FRAMES_RESET;
		fault_cnt = '0;
		hit_cnt = '0;
		for (k = 0; k < FRAME_SLOTS; k++) begin
			frm_page[k] = '0;
			frm_valid[k] = 1'b0;
			frm_rank[k] = '0;
		end

		// Four frames after reset: fills, a hit, then the oldest page goes.
		add_row(ROW_PAGE,   16'h0000, 1, 0, 0, 0, 16'h0000);
		add_row(ROW_PAGE,   16'hFFFF, 1, 0, 1, 0, 16'h0000);
		add_row(ROW_PAGE,   16'h0000, 1, 1, 0, 0, 16'h0000);
		add_row(ROW_PAGE,   16'h1234, 1, 0, 2, 0, 16'h0000);
		add_row(ROW_PAGE,   16'hABCD, 1, 0, 3, 0, 16'h0000);
		add_row(ROW_PAGE,   16'h5555, 1, 0, 1, 1, 16'hFFFF);
		add_row(ROW_PAGE,   16'h0000, 1, 1, 0, 0, 16'h0000);
		// A count of zero leaves one frame active.
		add_row(ROW_FRAMES, 16'd0,    0, 0, 0, 0, 16'h0000);
		add_row(ROW_PAGE,   16'h0000, 1, 1, 0, 0, 16'h0000);
		add_row(ROW_PAGE,   16'h0007, 1, 0, 0, 1, 16'h0000);
		// An oversized count clamps to all frames; the old pages come back.
		add_row(ROW_FRAMES, 16'd31,   0, 0, 0, 0, 16'h0000);
		add_row(ROW_PAGE,   16'hFFFF, 1, 0, 4, 0, 16'h0000);
		add_row(ROW_PAGE,   16'h1234, 1, 1, 2, 0, 16'h0000);
		// One frame again, then a duplicate page in frames 0 and 4.
		add_row(ROW_FRAMES, 16'd1,    0, 0, 0, 0, 16'h0000);
		add_row(ROW_PAGE,   16'hFFFF, 1, 0, 0, 1, 16'h0007);
		add_row(ROW_FRAMES, 16'd16,   0, 0, 0, 0, 16'h0000);
		add_row(ROW_PAGE,   16'hFFFF, 1, 1, 0, 0, 16'h0000);
		add_row(ROW_PAGE,   16'h8000, 1, 0, 5, 0, 16'h0000);
		add_row(ROW_PAGE,   16'h0001, 0, 0, 0, 0, 16'h0000);
		add_row(ROW_FRAMES, 16'd17,   0, 0, 0, 0, 16'h0000);
		add_row(ROW_PAGE,   16'h5555, 1, 1, 1, 0, 16'h0000);
		add_row(ROW_FRAMES, 16'd2,    0, 0, 0, 0, 16'h0000);
		add_row(ROW_PAGE,   16'h2222, 0, 0, 0, 0, 16'h0000);
		add_row(ROW_PAGE,   16'h4444, 0, 0, 0, 0, 16'h0000);
		add_row(ROW_FRAMES, 16'd4,    0, 0, 0, 0, 16'h0000);
		add_row(ROW_PAGE,   16'hABCD, 0, 0, 0, 0, 16'h0000);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_FRAMES) begin
				write_frames(dir_rows[k].value[lpr_pkg::CFG_W-1:0]);
			end else begin
				send_page(dir_rows[k].value, dir_rows[k].typed, dir_rows[k]);
			end
		end

		phase_frames = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd16,
			5'($urandom_range(0, 31)), 5'd3, 5'd17, 5'($urandom_range(0, 31))};
		for (k = 0; k < NUM_PHASES; k++) begin
			write_frames(phase_frames[k]);
			quiet = (k == 5);
			// A pool a little larger than the frame set gives a mix of hits and evictions.
			pool_size = active_count() + $urandom_range(0, 6);
			for (w = 0; w < pool_size; w++) begin
				pool[w] = 16'($urandom());
			end
			for (w = 0; w < PHASE_WORDS; w++) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					pg = 16'($urandom());
				end else if (pick < 12) begin
					pg = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				end else begin
					pg = pool[$urandom_range(0, pool_size - 1)];
				end
				if ($urandom_range(0, 99) < 5) begin
					pool[$urandom_range(0, pool_size - 1)] = 16'($urandom());
				end
				send_page(pg, 1'b0, none);
			end
		end
		quiet = 1'b0;

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (mismatch_cnt == 0 && expected_results.size() == 0) begin
			$display("tb_lru_page_replacement OK");
		end else begin
			$display("tb_lru_page_replacement NOT OK");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/lpr_pkg.sv
rtl/core/lpr_page_ram.sv
rtl/core/lpr_engine.sv
rtl/core/lru_page_replacement.sv
tb/tb_lru_page_replacement.sv
